// ===== hw/rtl/itamd_pkg.sv =====
// Shared constants, codes and types for the interest table block.
// No dependencies; every other file in hw/rtl imports this package.
package itamd_pkg;

    localparam int SLOTS      = 8;
    localparam int INSTANCES  = 2;
    localparam int ENTRIES    = SLOTS * INSTANCES;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ADDR_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam int OP_W       = 2;
    localparam int KEY_W      = 8;
    localparam int MASK_W     = 32;
    localparam int DATA_W     = 64;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 2'd0,
        OP_MOD = 2'd1,
        OP_DEL = 2'd2,
        OP_NOP = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EXISTS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // running result of one table scan
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic              free;
        logic [SLOT_W-1:0] free_slot;
    } t_scan_res;

    // one write into the entry store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic              used_we;
        logic              used_val;
        logic              key_we;
        logic [KEY_W-1:0]  key;
        logic [MASK_W-1:0] mask;
        logic [DATA_W-1:0] data;
    } t_store_wr;

endpackage

// ===== hw/rtl/itamd_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on itamd_pkg for field widths.
interface itamd_req_if import itamd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   req_type;
    logic              instance_req;
    logic [KEY_W-1:0]  key_fd;
    logic [MASK_W-1:0] event_mask;
    logic [DATA_W-1:0] event_data;

    modport source (
        output valid, req_type, instance_req, key_fd, event_mask, event_data,
        input  ready
    );
    modport sink (
        input  valid, req_type, instance_req, key_fd, event_mask, event_data,
        output ready
    );
endinterface

interface itamd_rsp_if import itamd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;

    modport source (output valid, status, slot, input ready);
    modport sink   (input valid, status, slot, output ready);
endinterface

// ===== hw/rtl/itamd_store.sv =====
// Entry store: used bits in flops, key/mask/data in memories.
// One registered read port, one write port. Depends on itamd_pkg.
module itamd_store import itamd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic              o_rd_used,
    output logic [KEY_W-1:0]  o_rd_key,
    input  t_store_wr         i_wr
);

    logic [ENTRIES-1:0] r_used;
    logic [KEY_W-1:0]   r_key_mem  [ENTRIES];
    logic [MASK_W-1:0]  r_mask_mem [ENTRIES];
    logic [DATA_W-1:0]  r_data_mem [ENTRIES];
    logic               r_rd_used;
    logic [KEY_W-1:0]   r_rd_key;

    // used bits need a defined reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_wr.en && i_wr.used_we) begin
            r_used[i_wr.addr] <= i_wr.used_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mask_mem[i_wr.addr] <= i_wr.mask;
            r_data_mem[i_wr.addr] <= i_wr.data;
            if (i_wr.key_we) begin
                r_key_mem[i_wr.addr] <= i_wr.key;
            end
        end
        r_rd_used <= r_used[i_rd_addr];
        r_rd_key  <= r_key_mem[i_rd_addr];
    end

    assign o_rd_used = r_rd_used;
    assign o_rd_key  = r_rd_key;

endmodule

// ===== hw/rtl/itamd_scan.sv =====
// Shared key compare unit: looks at one slot per cycle and keeps the
// last match and highest free slot seen. Depends on itamd_pkg.
module itamd_scan import itamd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_clear,
    input  logic              i_vld,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic              i_used,
    input  logic [KEY_W-1:0]  i_key_ent,
    input  logic [KEY_W-1:0]  i_key_req,
    output t_scan_res         o_res
);

    t_scan_res r_res;
    logic      w_match;

    assign w_match = i_used && (i_key_ent == i_key_req);

    // slots arrive in rising order, so a later slot simply overwrites
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_res <= '0;
        end else if (i_vld) begin
            if (w_match) begin
                r_res.hit      <= 1'b1;
                r_res.hit_slot <= i_slot;
            end
            if (!i_used) begin
                r_res.free      <= 1'b1;
                r_res.free_slot <= i_slot;
            end
        end
    end

    assign o_res = r_res;

endmodule

// ===== hw/rtl/interest_table_add_mod_del.sv =====
// Interest tables: INSTANCES tables of SLOTS entries (key, event mask, data).
// Each request adds, modifies or deletes one entry of the table picked by
// instance_req and returns one response with a status and the slot touched
// (slot is zero unless status is ok). A request scans its table one slot per
// cycle through the single read port of the key memory and one shared key
// comparator, then commits one write. From its acceptance to the earliest
// next acceptance a request passes through the scan of all slots, a drain
// state for the last read to land, the commit, a done state that loads the
// response register, and the idle state. The response sits in its own
// register, so the next request is taken and scanned while a response
// still waits; it only stalls at the end if that response has not yet
// been taken. Reset clears the used bits only; the key, mask and data of
// a free slot are never used.
module interest_table_add_mod_del import itamd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    itamd_req_if.sink   i_req,
    itamd_rsp_if.source o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT,
        S_DONE
    } t_state;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    t_state               r_state;
    logic [SLOT_W-1:0]    r_cnt;
    logic                 r_pend_vld;
    logic [SLOT_W-1:0]    r_pend_slot;

    // captured request
    t_op                  r_op;
    logic [ADDR_W-1:0]    r_base;
    logic [KEY_W-1:0]     r_key;
    logic [MASK_W-1:0]    r_mask;
    logic [DATA_W-1:0]    r_data;

    // result waiting for the response register
    t_status              r_res_status;
    logic [SLOT_W-1:0]    r_res_slot;

    // response register
    logic                 r_out_vld;
    t_status              r_out_status;
    logic [SLOT_OUT_W-1:0] r_out_slot;

    logic                 w_accept;
    logic [ADDR_W-1:0]    w_rd_addr;
    logic                 w_rd_used;
    logic [KEY_W-1:0]     w_rd_key;
    t_scan_res            w_scan;
    t_store_wr            w_wr;
    t_status              n_status;
    logic [SLOT_W-1:0]    n_slot;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_rd_addr   = r_base + ADDR_W'(r_cnt);

    itamd_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .o_rd_used (w_rd_used),
        .o_rd_key  (w_rd_key),
        .i_wr      (w_wr)
    );

    itamd_scan u_scan (
        .i_clk     (i_clk),
        .i_clear   (w_accept),
        .i_vld     (r_pend_vld),
        .i_slot    (r_pend_slot),
        .i_used    (w_rd_used),
        .i_key_ent (w_rd_key),
        .i_key_req (r_key),
        .o_res     (w_scan)
    );

    // commit decision from the finished scan
    always_comb begin
        n_status      = ST_OK;
        n_slot        = '0;
        w_wr          = '0;
        w_wr.key      = r_key;
        w_wr.mask     = r_mask;
        w_wr.data     = r_data;
        if (r_state == S_COMMIT) begin
            unique case (r_op)
                OP_ADD: begin
                    // duplicate check covers the whole table before the free check
                    if (w_scan.hit) begin
                        n_status = ST_EXISTS;
                    end else if (!w_scan.free) begin
                        n_status = ST_FULL;
                    end else begin
                        n_slot        = w_scan.free_slot;
                        w_wr.en       = 1'b1;
                        w_wr.addr     = r_base + ADDR_W'(w_scan.free_slot);
                        w_wr.used_we  = 1'b1;
                        w_wr.used_val = 1'b1;
                        w_wr.key_we   = 1'b1;
                    end
                end
                OP_MOD: begin
                    if (!w_scan.hit) begin
                        n_status = ST_NOTFOUND;
                    end else begin
                        n_slot    = w_scan.hit_slot;
                        w_wr.en   = 1'b1;
                        w_wr.addr = r_base + ADDR_W'(w_scan.hit_slot);
                    end
                end
                OP_DEL: begin
                    if (!w_scan.hit) begin
                        n_status = ST_NOTFOUND;
                    end else begin
                        n_slot        = w_scan.hit_slot;
                        w_wr.en       = 1'b1;
                        w_wr.addr     = r_base + ADDR_W'(w_scan.hit_slot);
                        w_wr.used_we  = 1'b1;
                        w_wr.used_val = 1'b0;
                        w_wr.mask     = '0;
                        w_wr.data     = '0;
                    end
                end
                OP_NOP: begin
                    // unused code: no change, ok with slot zero
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_pend_vld  <= (r_state == S_SCAN);
            r_pend_slot <= r_cnt;

            // in S_DONE the response register is handled below
            if (r_out_vld && o_rsp.ready && r_state != S_DONE) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op   <= t_op'(i_req.req_type);
                        // a single table swallows every instance number
                        r_base <= (INSTANCES > 1 && i_req.instance_req) ?
                                  ADDR_W'(SLOTS) : '0;
                        r_key  <= i_req.key_fd;
                        r_mask <= i_req.event_mask;
                        r_data <= i_req.event_data;
                        r_cnt  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cnt == LAST_SLOT) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    r_res_status <= n_status;
                    r_res_slot   <= n_slot;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    // hold until the response register is free or emptying
                    if (!r_out_vld || o_rsp.ready) begin
                        r_out_vld    <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_slot   <= SLOT_OUT_W'(r_res_slot);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid  = r_out_vld;
    assign o_rsp.status = r_out_status;
    assign o_rsp.slot   = r_out_slot;

    // store is only written at commit
    a_wr_only_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> (r_state == S_COMMIT))
        else $error("store write outside commit");

    // a failed request never reports a slot
    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_status != ST_OK) |-> (r_out_slot == '0))
        else $error("nonzero slot on failed request");

    // a pending response blocks the next one from overwriting it
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_vld && !o_rsp.ready) |=> (r_state == S_DONE))
        else $error("response register overwritten");

    // scan ends after the last slot was read
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_cnt == LAST_SLOT) |=> (r_state == S_DRAIN && r_pend_vld))
        else $error("scan did not finish on last slot");

endmodule

// ===== dv/interest_table_checker.sv =====
`timescale 1ns / 100ps
// Response checker for the interest table block: keeps its own copy of both
// tables, predicts status and slot per request and compares them in order.
// Depends on itamd_pkg and the channel interfaces of itamd_if.sv.
module interest_table_checker import itamd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    itamd_req_if             i_req,
    itamd_rsp_if             i_rsp,
    output int               o_fail_count,
    output int               o_outstanding,
    output int               o_checked,
    output logic [3:0][31:0] o_status_cnt
);

    typedef struct packed {
        t_status               status;
        logic [SLOT_OUT_W-1:0] slot;
    } t_table_rsp;

    logic              tbl_used [INSTANCES][SLOTS];
    logic [KEY_W-1:0]  tbl_key  [INSTANCES][SLOTS];
    logic [MASK_W-1:0] tbl_mask [INSTANCES][SLOTS];
    logic [DATA_W-1:0] tbl_data [INSTANCES][SLOTS];

    t_table_rsp        pending_rsp [$];
    int                fails;
    int                checked;
    logic [3:0][31:0]  status_cnt;

    // Applies one request to the mirrored table and returns its answer.
    function automatic t_table_rsp apply_table_request(
        t_op op, int unsigned tbl, logic [KEY_W-1:0] key,
        logic [MASK_W-1:0] mask, logic [DATA_W-1:0] data);
        t_table_rsp r;
        int         free_idx;
        int         hit_idx;
        int         s;
        r.status = ST_OK;
        r.slot   = '0;
        free_idx = -1;
        hit_idx  = -1;
        for (s = 0; s < SLOTS; s++) begin
            if (tbl_used[tbl][s]) begin
                if (tbl_key[tbl][s] == key) hit_idx = s;
            end else begin
                free_idx = s;
            end
        end
        case (op)
            OP_ADD: begin
                // duplicate check wins over a full table
                if (hit_idx >= 0) begin
                    r.status = ST_EXISTS;
                end else if (free_idx < 0) begin
                    r.status = ST_FULL;
                end else begin
                    tbl_used[tbl][free_idx] = 1'b1;
                    tbl_key[tbl][free_idx]  = key;
                    tbl_mask[tbl][free_idx] = mask;
                    tbl_data[tbl][free_idx] = data;
                    r.slot = free_idx[SLOT_OUT_W-1:0];
                end
            end
            OP_MOD: begin
                if (hit_idx < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    tbl_mask[tbl][hit_idx] = mask;
                    tbl_data[tbl][hit_idx] = data;
                    r.slot = hit_idx[SLOT_OUT_W-1:0];
                end
            end
            OP_DEL: begin
                if (hit_idx < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    tbl_used[tbl][hit_idx] = 1'b0;
                    tbl_mask[tbl][hit_idx] = '0;
                    tbl_data[tbl][hit_idx] = '0;
                    r.slot = hit_idx[SLOT_OUT_W-1:0];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_table_rsp want;
        int         t;
        int         s;
        if (!i_rst_n) begin
            for (t = 0; t < INSTANCES; t++)
                for (s = 0; s < SLOTS; s++)
                    tbl_used[t][s] = 1'b0;
            pending_rsp.delete();
            fails      = 0;
            checked    = 0;
            status_cnt = '0;
        end else begin
            // a response always belongs to an older request, so check first
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_rsp.size() == 0) begin
                    $error("response with none pending: status %0d slot %0d",
                           i_rsp.status, i_rsp.slot);
                    fails++;
                end else begin
                    want = pending_rsp.pop_front();
                    if (i_rsp.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_rsp.status);
                        fails++;
                    end
                    if (i_rsp.slot !== want.slot) begin
                        $error("slot: expected %0d, got %0d", want.slot, i_rsp.slot);
                        fails++;
                    end
                    checked++;
                    status_cnt[want.status] = status_cnt[want.status] + 1;
                end
            end
            if (i_req.valid && i_req.ready)
                pending_rsp.push_back(apply_table_request(t_op'(i_req.req_type),
                    i_req.instance_req % INSTANCES, i_req.key_fd,
                    i_req.event_mask, i_req.event_data));
        end
        o_fail_count  <= fails;
        o_outstanding <= pending_rsp.size();
        o_checked     <= checked;
        o_status_cnt  <= status_cnt;
    end

endmodule

// ===== dv/interest_table_add_mod_del_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for interest_table_add_mod_del: clock, reset, requests,
// response back-pressure and the verdict; checking lives in the checker.
// Depends on itamd_pkg, itamd_if.sv, the block and interest_table_checker.
module interest_table_add_mod_del_tb;
    import itamd_pkg::*;

    localparam int RANDOM_REQS   = 1800;
    localparam int POOL_SZ       = 12;
    // settle time after the last response: one full scan plus margin
    localparam int DRAIN_CYCLES  = 2 * SLOTS + 8;

    logic i_clk = 1'b0;
    logic i_rst_n;

    itamd_req_if req_ch ();
    itamd_rsp_if rsp_ch ();

    int               fail_count;
    int               outstanding;
    int               checked;
    logic [3:0][31:0] status_cnt;

    int               ops_sent [4];
    int               burst_left;
    logic [8:0]       rx_cycle = '0;
    int               rx_hold  = 0;

    interest_table_add_mod_del dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    interest_table_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_status_cnt  (status_cnt)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Response back-pressure. Four phases, picked by the top bits of rx_cycle:
    // always ready, light random stalls, long hold-offs, fixed toggling.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1'b1;
        case (rx_cycle[8:7])
            2'd0: rsp_ch.ready <= 1'b1;
            2'd1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2'd2: begin
                if (rx_hold != 0) begin
                    rx_hold      <= rx_hold - 1;
                    rsp_ch.ready <= 1'b0;
                end else begin
                    rsp_ch.ready <= 1'b1;
                    rx_hold      <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
                end
            end
            default: rsp_ch.ready <= rx_cycle[1] ^ rx_cycle[3];
        endcase
    end

    // Drive one request and hold it until the block takes it.
    // valid is only raised here; lowering is left to the pacing tasks.
    task automatic send_request(t_op op, logic inst, logic [KEY_W-1:0] key,
                                logic [MASK_W-1:0] mask, logic [DATA_W-1:0] data);
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= op;
        req_ch.instance_req <= inst;
        req_ch.key_fd       <= key;
        req_ch.event_mask   <= mask;
        req_ch.event_data   <= data;
        do @(posedge i_clk); while (!req_ch.ready);
        ops_sent[op]++;
    endtask

    // Burst/gap pacing: keep valid up inside a burst, drop it for a gap
    // between bursts. Occasional long bursts give gap-free stretches.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // Park the sender until every predicted response has come back.
    // The extra edge lets the checker count the request just taken.
    task automatic wait_tables_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic directed_request(t_op op, logic inst, logic [KEY_W-1:0] key,
                                    logic [MASK_W-1:0] mask, logic [DATA_W-1:0] data);
        send_request(op, inst, key, mask, data);
        pace_sender();
    endtask

    initial begin : stimulus
        logic [KEY_W-1:0]  key_pool [POOL_SZ];
        logic [KEY_W-1:0]  key;
        logic [MASK_W-1:0] mask;
        logic [DATA_W-1:0] data;
        t_op               op;
        int                pick;
        int                k;
        int                n;

        req_ch.valid        = 1'b0;
        req_ch.req_type     = OP_NOP;
        req_ch.instance_req = 1'b0;
        req_ch.key_fd       = '0;
        req_ch.event_mask   = '0;
        req_ch.event_data   = '0;
        i_rst_n             = 1'b0;
        burst_left          = 0;
        for (k = 0; k < 4; k++) ops_sent[k] = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part, table 0 unless noted ----
        // lookups on an empty table miss
        directed_request(OP_MOD, 1'b0, 8'd5, '1, '1);
        directed_request(OP_DEL, 1'b0, 8'd5, '0, '0);
        // extreme keys and payloads; adds fill from the top slot down
        directed_request(OP_ADD, 1'b0, 8'd0, '0, '0);
        directed_request(OP_ADD, 1'b0, 8'd255, '1, '1);
        directed_request(OP_ADD, 1'b0, 8'd0, $urandom, {$urandom, $urandom});
        for (k = 1; k <= 6; k++)
            directed_request(OP_ADD, 1'b0, k[KEY_W-1:0], $urandom, {$urandom, $urandom});
        // table now full: a new key is refused, a known key reports exists
        directed_request(OP_ADD, 1'b0, 8'd9, '1, '0);
        directed_request(OP_ADD, 1'b0, 8'd255, '0, '1);
        directed_request(OP_MOD, 1'b0, 8'd255, '0, '0);
        directed_request(OP_MOD, 1'b0, 8'd3, '1, '1);
        directed_request(OP_DEL, 1'b0, 8'd0, '1, '1);
        directed_request(OP_DEL, 1'b0, 8'd0, '0, '0);
        directed_request(OP_ADD, 1'b0, 8'd200, $urandom, {$urandom, $urandom});
        // free two slots in the middle; the next add takes the higher one
        directed_request(OP_DEL, 1'b0, 8'd4, '0, '0);
        directed_request(OP_DEL, 1'b0, 8'd1, '0, '0);
        directed_request(OP_ADD, 1'b0, 8'd10, $urandom, {$urandom, $urandom});
        // unused op code answers ok, slot 0, changes nothing
        directed_request(OP_NOP, 1'b0, 8'd255, '1, '1);
        // table 1 is independent of table 0
        directed_request(OP_ADD, 1'b1, 8'd255, '1, '1);
        directed_request(OP_MOD, 1'b1, 8'd0, '0, '0);
        send_request(OP_NOP, 1'b1, 8'd0, $urandom, {$urandom, $urandom});
        // hold off until the block has answered everything
        wait_tables_idle();

        // ---- random part ----
        // Keys come mostly from a small pool so adds collide, tables fill
        // and deletes hit. The op mix swings between filling and draining.
        for (n = 0; n < RANDOM_REQS; n++) begin
            if (n % 150 == 0)
                for (k = 0; k < POOL_SZ; k++)
                    key_pool[k] = (k == 0) ? 8'd0 : (k == 1) ? 8'd255
                                                          : 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if ((n / 200) % 2 == 0)
                op = (pick < 55) ? OP_ADD : (pick < 70) ? OP_MOD : (pick < 96) ? OP_DEL : OP_NOP;
            else
                op = (pick < 25) ? OP_ADD : (pick < 45) ? OP_MOD : (pick < 96) ? OP_DEL : OP_NOP;

            key  = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SZ - 1)]
                                                : 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 19);
            mask = (pick == 0) ? '0 : (pick == 1) ? '1 : MASK_W'($urandom);
            pick = $urandom_range(0, 19);
            data = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};

            send_request(op, 1'($urandom_range(0, 1)), key, mask, data);
            if (n % 250 == 249)
                wait_tables_idle();
            else
                pace_sender();
        end

        wait_tables_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("requests: %0d add, %0d modify, %0d delete, %0d unused op",
                 ops_sent[OP_ADD], ops_sent[OP_MOD], ops_sent[OP_DEL], ops_sent[OP_NOP]);
        $display("responses checked: %0d (ok %0d, exists %0d, full %0d, not found %0d)",
                 checked, status_cnt[ST_OK], status_cnt[ST_EXISTS],
                 status_cnt[ST_FULL], status_cnt[ST_NOTFOUND]);
        if (fail_count == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: several times the slowest legal run
    // (~1820 requests, each with its scan, pacing gap and response stall).
    initial begin
        #4_000_000;
        $error("timeout: %0d responses still pending", outstanding);
        $display("== FAIL ==");
        $finish;
    end

endmodule
